// File: rtl/core/ppc_pkg.sv
// ----------------------------------------------------------------------------
// Procedural pattern colour package
// Shared types and constants for the pattern colour pipeline: pattern kinds,
// register indexes, coordinate widths and the structs that run down the chain.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // Fixed widths taken from the interface.
  localparam int unsigned CoordW   = 32;  // signed fixed-point coordinate
  localparam int unsigned RadW     = 64;  // radicand x*x + z*z
  localparam int unsigned RootW    = 32;  // full square root width
  localparam int unsigned RemW     = 34;  // partial remainder of the root
  localparam int unsigned FracMaxW = 24;  // largest supported fraction width
  localparam int unsigned FieldW   = 16;  // colour field width on the ports
  localparam int unsigned RegIdxW  = 3;   // register index width
  localparam int unsigned AddrW    = 5;   // byte address width of the port
  localparam int unsigned DataW    = 32;  // configuration data width

  // Pattern kinds.
  typedef enum logic [1:0] {
    KindStripe   = 2'd0,
    KindGradient = 2'd1,
    KindRing     = 2'd2,
    KindChecker  = 2'd3
  } kind_e;

  // Register indexes on the configuration port.
  localparam logic [RegIdxW-1:0] RegKind        = 3'd0;
  localparam logic [RegIdxW-1:0] RegFirstRed    = 3'd1;
  localparam logic [RegIdxW-1:0] RegFirstGreen  = 3'd2;
  localparam logic [RegIdxW-1:0] RegFirstBlue   = 3'd3;
  localparam logic [RegIdxW-1:0] RegSecondRed   = 3'd4;
  localparam logic [RegIdxW-1:0] RegSecondGreen = 3'd5;
  localparam logic [RegIdxW-1:0] RegSecondBlue  = 3'd6;

  // Item side band carried alongside the root computation.
  typedef struct packed {
    logic                valid;
    kind_e               kind;
    logic                odd;   // parity for the striped, ring and checkered kinds
    logic [FracMaxW-1:0] frac;  // fractional part of x for the gradient
  } ppc_side_t;

  // Digit-by-digit square root state handed from cell to cell.
  typedef struct packed {
    logic [RadW-1:0]  rad;   // radicand bits not yet consumed, MSB first
    logic [RemW-1:0]  rem;   // running remainder
    logic [RootW-1:0] root;  // root bits found so far
  } ppc_root_t;

endpackage

// File: rtl/core/ppc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One step of the restoring digit-by-digit square root: takes two radicand
// bits, decides one root bit and passes the state and side band onward.
// ----------------------------------------------------------------------------
module ppc_sqrt_cell
  import ppc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  ppc_side_t side_i,
  input  ppc_root_t root_i,
  output ppc_side_t side_o,
  output ppc_root_t root_o
);

  ppc_side_t        side_q;
  ppc_root_t        root_q;
  ppc_root_t        root_d;
  logic [RemW-1:0]  rem_shift;
  logic [RemW-1:0]  trial;

  // Bring down the next bit pair and try to subtract 4*root + 1.
  always_comb begin
    rem_shift = {root_i.rem[RemW-3:0], root_i.rad[RadW-1 -: 2]};
    trial     = {root_i.root, 2'b01};
    root_d.rad = {root_i.rad[RadW-3:0], 2'b00};
    if (rem_shift >= trial) begin
      root_d.rem  = rem_shift - trial;
      root_d.root = {root_i.root[RootW-2:0], 1'b1};
    end else begin
      root_d.rem  = rem_shift;
      root_d.root = {root_i.root[RootW-2:0], 1'b0};
    end
  end

  // Side band register, cleared on reset so that no stale beat appears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  // Root state register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
    end
  end

  assign side_o = side_q;
  assign root_o = root_q;

endmodule

// File: rtl/core/ppc_shade.sv
// ----------------------------------------------------------------------------
// Colour shading stages
// Forms the gradient blend products, then either rounds the blend or picks
// colour one or two by parity, into the output register.
// ----------------------------------------------------------------------------
module ppc_shade
  import ppc_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  ppc_side_t                           side_i,
  input  logic [2:0][CHANNEL_BITS-1:0]        first_i,
  input  logic [2:0][CHANNEL_BITS-1:0]        second_i,
  output logic                                valid_o,
  output logic [2:0][FieldW-1:0]              chan_o
);

  localparam int unsigned ProdW = CHANNEL_BITS + FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] One  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ProdW:0]     Half = (ProdW+1)'(One >> 1);

  logic [FRAC_BITS:0]              frac;
  logic [FRAC_BITS:0]              inv;
  logic [2:0][ProdW-1:0]           pa_d, pb_d;
  logic [2:0][ProdW-1:0]           pa_q, pb_q;
  logic                            d_valid_q;
  kind_e                           d_kind_q;
  logic                            d_odd_q;
  logic [2:0][ProdW:0]             sum;
  logic [2:0][FieldW-1:0]          chan_d;
  logic [2:0][FieldW-1:0]          chan_q;
  logic                            valid_q;

  // Blend weights: colour one by 1 - f, colour two by f.
  always_comb begin
    frac = {1'b0, side_i.frac[FRAC_BITS-1:0]};
    inv  = One - frac;
    for (int c = 0; c < 3; c++) begin
      pa_d[c] = ProdW'(first_i[c]) * ProdW'(inv);
      pb_d[c] = ProdW'(second_i[c]) * ProdW'(frac);
    end
  end

  // Product stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      d_kind_q  <= KindStripe;
      d_odd_q   <= 1'b0;
    end else if (en_i) begin
      d_valid_q <= side_i.valid;
      d_kind_q  <= side_i.kind;
      d_odd_q   <= side_i.odd;
    end
  end

  // Product stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  // Round the blend to nearest, or pick a colour by parity.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = {1'b0, pa_q[c]} + {1'b0, pb_q[c]} + Half;
      if (d_kind_q == KindGradient) begin
        chan_d[c] = FieldW'(sum[c][FRAC_BITS+CHANNEL_BITS-1:FRAC_BITS]);
      end else if (d_odd_q) begin
        chan_d[c] = FieldW'(second_i[c]);
      end else begin
        chan_d[c] = FieldW'(first_i[c]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q <= chan_d;
    end
  end

  assign valid_o = valid_q;
  assign chan_o  = chan_q;

endmodule

// File: rtl/core/procedural_pattern_color.sv
// ----------------------------------------------------------------------------
// Procedural pattern colour
// Colours a pattern-space point as stripes, gradient, rings or checkers.
//
//   Channel  Direction  Handshake            Beat contents
//   in       input      in_valid/in_ready    x_coord, y_coord, z_coord
//   out      output     out_valid/out_ready  out_red, out_green, out_blue
//   config   input      APB psel/penable     seven colour and kind registers
//
// One beat is accepted every cycle unless the output stalls; a result passes
// the input, square and sum stages, the chain of square root cells, one per
// root bit down to the integer bit of the ring radius, then the shade stages.
// Reset clears every valid bit and loads the register reset values.
// A stalled output register holds the whole pipeline, and in_ready drops.
// ----------------------------------------------------------------------------
module procedural_pattern_color
  import ppc_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Point channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] x_coord_i,
  input  logic signed [CoordW-1:0] y_coord_i,
  input  logic signed [CoordW-1:0] z_coord_i,
  // Colour channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [FieldW-1:0]        out_red_o,
  output logic [FieldW-1:0]        out_green_o,
  output logic [FieldW-1:0]        out_blue_o,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

  localparam int unsigned NumCells = CoordW - FRAC_BITS;

  kind_e                          kind_q;
  logic [2:0][CHANNEL_BITS-1:0]   first_q, second_q;
  logic                           cfg_wr;
  logic [RegIdxW-1:0]             cfg_idx;
  logic                           en;
  logic [CoordW-1:0]              ax, az;
  ppc_side_t                      a_side_d;
  ppc_side_t                      a_side_q, b_side_q, c_side_q;
  logic [CoordW-1:0]              a_ax_q, a_az_q;
  logic [RadW-1:0]                sqx, sqz;
  logic [RadW-1:0]                b_sqx_q, b_sqz_q;
  ppc_root_t                      c_root_q;
  ppc_side_t                      side_w [NumCells+1];
  ppc_root_t                      root_w [NumCells+1];
  ppc_side_t                      shade_side;
  logic [2:0][FieldW-1:0]         chan;
  logic [2:0][FieldW-1:0]         first_ext, second_ext;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= KindStripe;
      first_q  <= '0;
      second_q <= '1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegKind:        kind_q      <= kind_e'(pwdata[1:0]);
        RegFirstRed:    first_q[0]  <= pwdata[CHANNEL_BITS-1:0];
        RegFirstGreen:  first_q[1]  <= pwdata[CHANNEL_BITS-1:0];
        RegFirstBlue:   first_q[2]  <= pwdata[CHANNEL_BITS-1:0];
        RegSecondRed:   second_q[0] <= pwdata[CHANNEL_BITS-1:0];
        RegSecondGreen: second_q[1] <= pwdata[CHANNEL_BITS-1:0];
        RegSecondBlue:  second_q[2] <= pwdata[CHANNEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      RegKind:        prdata = DataW'(kind_q);
      RegFirstRed:    prdata = DataW'(first_q[0]);
      RegFirstGreen:  prdata = DataW'(first_q[1]);
      RegFirstBlue:   prdata = DataW'(first_q[2]);
      RegSecondRed:   prdata = DataW'(second_q[0]);
      RegSecondGreen: prdata = DataW'(second_q[1]);
      RegSecondBlue:  prdata = DataW'(second_q[2]);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: every stage moves while the output register can advance.
  // --------------------------------------------------------------------------
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Input stage: magnitudes for the ring and the cheap parities.
  // --------------------------------------------------------------------------
  always_comb begin
    ax = x_coord_i[CoordW-1] ? (~x_coord_i + CoordW'(1'b1)) : x_coord_i;
    az = z_coord_i[CoordW-1] ? (~z_coord_i + CoordW'(1'b1)) : z_coord_i;
    a_side_d.valid = in_valid_i;
    a_side_d.kind  = kind_q;
    a_side_d.frac  = FracMaxW'(x_coord_i[FRAC_BITS-1:0]);
    case (kind_q)
      KindStripe:  a_side_d.odd = x_coord_i[FRAC_BITS];
      KindChecker: a_side_d.odd = x_coord_i[FRAC_BITS] ^ y_coord_i[FRAC_BITS]
                                  ^ z_coord_i[FRAC_BITS];
      default:     a_side_d.odd = 1'b0;
    endcase
  end

  // Side band through the input, square and sum stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_side_q <= '0;
      b_side_q <= '0;
      c_side_q <= '0;
    end else if (en) begin
      a_side_q <= a_side_d;
      b_side_q <= a_side_q;
      c_side_q <= b_side_q;
    end
  end

  // Square each magnitude, then sum into the radicand.
  assign sqx = RadW'(a_ax_q) * RadW'(a_ax_q);
  assign sqz = RadW'(a_az_q) * RadW'(a_az_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ax_q        <= ax;
      a_az_q        <= az;
      b_sqx_q       <= sqx;
      b_sqz_q       <= sqz;
      c_root_q.rad  <= b_sqx_q + b_sqz_q;
      c_root_q.rem  <= '0;
      c_root_q.root <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Square root chain: one cell per root bit down to the integer LSB.
  // --------------------------------------------------------------------------
  assign side_w[0] = c_side_q;
  assign root_w[0] = c_root_q;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    ppc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (side_w[g]),
      .root_i (root_w[g]),
      .side_o (side_w[g+1]),
      .root_o (root_w[g+1])
    );
  end

  // The ring parity is the lowest bit of the integer radius.
  always_comb begin
    shade_side = side_w[NumCells];
    if (side_w[NumCells].kind == KindRing) begin
      shade_side.odd = root_w[NumCells].root[0];
    end
  end

  // --------------------------------------------------------------------------
  // Colour stages and output register
  // --------------------------------------------------------------------------
  ppc_shade #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .side_i   (shade_side),
    .first_i  (first_q),
    .second_i (second_q),
    .valid_o  (out_valid_o),
    .chan_o   (chan)
  );

  assign out_red_o   = chan[0];
  assign out_green_o = chan[1];
  assign out_blue_o  = chan[2];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      first_ext[c]  = FieldW'(first_q[c]);
      second_ext[c] = FieldW'(second_q[c]);
    end
  end

  // Selected patterns return exactly colour one or colour two.
  a_pick_is_colour : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_q != KindGradient) |->
      ((chan == first_ext) || (chan == second_ext)))
    else $error("selected colour is neither colour one nor colour two");

  // A gradient red channel lies between the two end colours.
  a_blend_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_q == KindGradient) |->
      ((out_red_o >= first_ext[0] && out_red_o <= second_ext[0]) ||
       (out_red_o >= second_ext[0] && out_red_o <= first_ext[0])))
    else $error("gradient red outside the range of the end colours");

  // A result held back by the consumer is not dropped.
  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result lost while the output was stalled");

endmodule
